// ----- rtl/pcsm_pkg.sv -----
// Shared constants, types and helpers for the p-code stack machine core.
package pcsm_pkg;

    localparam int CODE_DEPTH  = 2048;
    localparam int STACK_DEPTH = 4096;
    localparam int MAX_LEVEL   = 3;
    localparam int WORD_WIDTH  = 32;

    localparam int CODE_AW  = $clog2(CODE_DEPTH);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int TOP_W    = STACK_AW + 1;
    localparam int IDX_W    = STACK_AW + 3;
    localparam int LV_CW    = $clog2(MAX_LEVEL + 1);
    localparam int INSTR_W  = 16;

    typedef logic signed [IDX_W-1:0] t_idx;
    typedef logic [WORD_WIDTH-1:0]   t_word;

    typedef struct packed {
        logic [2:0]  fn;
        logic [1:0]  lv;
        logic [10:0] a;
    } t_instr;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_EXEC    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] F_LIT = 3'd0;
    localparam logic [2:0] F_OPR = 3'd1;
    localparam logic [2:0] F_LOD = 3'd2;
    localparam logic [2:0] F_STO = 3'd3;
    localparam logic [2:0] F_CAL = 3'd4;
    localparam logic [2:0] F_INT = 3'd5;
    localparam logic [2:0] F_JMP = 3'd6;
    localparam logic [2:0] F_JPC = 3'd7;

    localparam logic [10:0] OPR_RET = 11'd0;
    localparam logic [10:0] OPR_NEG = 11'd1;
    localparam logic [10:0] OPR_ADD = 11'd2;
    localparam logic [10:0] OPR_SUB = 11'd3;
    localparam logic [10:0] OPR_MUL = 11'd4;
    localparam logic [10:0] OPR_DIV = 11'd5;
    localparam logic [10:0] OPR_ODD = 11'd6;
    localparam logic [10:0] OPR_EQ  = 11'd8;
    localparam logic [10:0] OPR_NE  = 11'd9;
    localparam logic [10:0] OPR_LT  = 11'd10;
    localparam logic [10:0] OPR_GE  = 11'd11;
    localparam logic [10:0] OPR_GT  = 11'd12;
    localparam logic [10:0] OPR_LE  = 11'd13;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    function automatic logic in_stack(input t_idx x);
        return (x >= t_idx'(0)) && (x < t_idx'(STACK_DEPTH));
    endfunction

    function automatic logic is_binary(input logic [10:0] a);
        return (a >= OPR_ADD && a <= OPR_DIV) || (a >= OPR_EQ && a <= OPR_LE);
    endfunction

endpackage

// ----- rtl/pcsm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pcsm_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// ----- rtl/pcsm_alu.sv -----
// Stack ALU: combinational arithmetic and compares, iterative signed divider.
module pcsm_alu import pcsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_op,
    input  t_word       i_x,
    input  t_word       i_y,
    input  logic        i_start,
    output t_word       o_res,
    output t_word       o_quo,
    output logic        o_done
);
    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic            r_busy, n_busy;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_word           r_q, n_q;
    t_word           r_rem, n_rem;
    t_word           r_ay, n_ay;
    logic            r_neg, n_neg;
    logic            r_done, n_done;
    logic [WORD_WIDTH:0] rem_sh;
    logic            nx, ny;

    always_comb begin
        unique case (i_op)
            OPR_ADD: o_res = i_x + i_y;
            OPR_SUB: o_res = i_x - i_y;
            OPR_MUL: o_res = i_x * i_y;
            OPR_EQ:  o_res = t_word'(i_x == i_y);
            OPR_NE:  o_res = t_word'(i_x != i_y);
            OPR_LT:  o_res = t_word'($signed(i_x) <  $signed(i_y));
            OPR_GE:  o_res = t_word'($signed(i_x) >= $signed(i_y));
            OPR_GT:  o_res = t_word'($signed(i_x) >  $signed(i_y));
            default: o_res = t_word'($signed(i_x) <= $signed(i_y));
        endcase
    end

    always_comb begin
        nx     = i_x[WORD_WIDTH-1];
        ny     = i_y[WORD_WIDTH-1];
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_ay   = r_ay;
        n_neg  = r_neg;
        n_done = 1'b0;
        rem_sh = {r_rem, r_q[WORD_WIDTH-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WORD_WIDTH);
            n_q    = nx ? (t_word'(0) - i_x) : i_x;
            n_ay   = ny ? (t_word'(0) - i_y) : i_y;
            n_rem  = '0;
            n_neg  = nx ^ ny;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_ay}) begin
                n_rem = WORD_WIDTH'(rem_sh - {1'b0, r_ay});
                n_q   = {r_q[WORD_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[WORD_WIDTH-1:0];
                n_q   = {r_q[WORD_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_ay  <= n_ay;
        r_neg <= n_neg;
    end

    assign o_quo  = r_neg ? (t_word'(0) - r_q) : r_q;
    assign o_done = r_done;
endmodule

// ----- rtl/pcode_stack_machine_core_unit.sv -----
// PL/0 p-code stack machine: sequencer, code and stack memories, output register.
//
// One word in, one word out. A load, a restart, an execute while halted and an
// executed instruction each end with a top-of-stack read; an instruction also
// walks one static link per level followed, and a divide waits on the iterative
// divider. Accesses are serialised by the single read port of the stack memory,
// which serves frame walks, operand fetches and the final top-of-stack read one
// access per cycle. A new word is taken once the previous result has entered the output register.
module pcode_stack_machine_core_unit import pcsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [10:0]        i_code_address,
    input  logic [2:0]         i_func_code,
    input  logic [1:0]         i_level_diff,
    input  logic [10:0]        i_operand_field,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [10:0]        o_prog_counter,
    output logic [11:0]        o_frame_base,
    output logic signed [12:0] o_stack_top_index,
    output logic signed [31:0] o_stack_top_value,
    output logic               o_halted,
    output logic [1:0]         o_fault_code
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_WALK2 = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_RD2   = 4'd6;
    localparam logic [3:0] S_OP    = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_CAL2  = 4'd9;
    localparam logic [3:0] S_CAL3  = 4'd10;
    localparam logic [3:0] S_TOPRD = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]              r_state, n_state;
    logic [CODE_AW-1:0]      r_pc, n_pc, r_np, n_np;
    logic [STACK_AW-1:0]     r_base, n_base, r_fb, n_fb, r_addr2, n_addr2;
    logic signed [TOP_W-1:0] r_top, n_top;
    logic                    r_halt, n_halt;
    logic [1:0]              r_fault, n_fault;
    t_instr                  r_ins, n_ins;
    logic [LV_CW-1:0]        r_cnt, n_cnt;
    logic [1:0]              r_clr, n_clr;
    t_word                   r_y, n_y;
    logic                    r_tv_ok, n_tv_ok;
    logic                    r_ov, n_ov;
    logic [10:0]             r_o_pc, n_o_pc;
    logic [11:0]             r_o_base, n_o_base;
    logic signed [12:0]      r_o_top, n_o_top;
    logic signed [31:0]      r_o_tv, n_o_tv;
    logic                    r_o_halt, n_o_halt;
    logic [1:0]              r_o_fault, n_o_fault;

    logic                    c_we, c_re;
    logic [CODE_AW-1:0]      c_waddr, c_raddr;
    t_instr                  c_wdata, c_rdata;
    logic                    s_we, s_re;
    logic [STACK_AW-1:0]     s_waddr, s_raddr;
    t_word                   s_wdata, s_rdata;
    t_word                   alu_res, alu_quo;
    logic                    alu_start, alu_done;

    logic                    accept, do_commit;
    logic [CODE_AW-1:0]      np_v;
    t_idx                    tx, bx, ax, fax;
    t_instr                  dec;
    logic [LV_CW-1:0]        lv_sat;

    pcsm_ram #(.AW(CODE_AW), .DW(INSTR_W)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    pcsm_ram #(.AW(STACK_AW), .DW(WORD_WIDTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    pcsm_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(r_ins.a), .i_x(s_rdata), .i_y(r_y),
        .i_start(alu_start), .o_res(alu_res), .o_quo(alu_quo), .o_done(alu_done)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;  n_pc = r_pc;      n_np = r_np;     n_base = r_base;
        n_fb = r_fb;        n_addr2 = r_addr2; n_top = r_top;  n_halt = r_halt;
        n_fault = r_fault;  n_ins = r_ins;    n_cnt = r_cnt;   n_clr = r_clr;
        n_y = r_y;          n_tv_ok = r_tv_ok; n_ov = r_ov;
        n_o_pc = r_o_pc;    n_o_base = r_o_base; n_o_top = r_o_top;
        n_o_tv = r_o_tv;    n_o_halt = r_o_halt; n_o_fault = r_o_fault;
        c_we = 1'b0; c_waddr = i_code_address[CODE_AW-1:0];
        c_wdata = '{fn: i_func_code, lv: i_level_diff, a: i_operand_field};
        c_re = 1'b0; c_raddr = r_pc;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
        alu_start = 1'b0;
        do_commit = 1'b0;
        np_v = r_np;
        tx  = t_idx'(r_top);
        bx  = t_idx'(r_base);
        ax  = t_idx'(r_ins.a);
        fax = t_idx'(r_fb) + ax;
        dec = c_rdata;
        lv_sat = (int'(dec.lv) > MAX_LEVEL) ? LV_CW'(MAX_LEVEL) : LV_CW'(dec.lv);

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fault = FAULT_NONE;
                    n_state = S_TOPRD;
                    unique case (i_opcode)
                        OP_LOAD: begin
                            c_we = ({1'b0, i_code_address} < 12'(CODE_DEPTH));
                        end
                        OP_RESTART: begin
                            n_pc = '0; n_base = '0; n_top = '1; n_halt = 1'b0;
                            n_clr = 2'd1;
                            n_state = S_CLR;
                        end
                        OP_EXEC: begin
                            if (!r_halt) begin
                                c_re = 1'b1;
                                n_state = S_DEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                s_we = 1'b1;
                s_waddr = STACK_AW'(r_clr);
                n_clr = r_clr + 2'd1;
                if (r_clr == 2'd3) begin
                    n_state = S_TOPRD;
                end
            end
            S_DEC: begin
                n_ins = dec;
                n_np = r_pc + 1'b1;
                n_fb = r_base;
                n_cnt = (dec.fn == F_LOD || dec.fn == F_STO || dec.fn == F_CAL) ?
                        lv_sat : '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = S_EXEC;
                end else if (!in_stack(t_idx'(r_fb))) begin
                    n_fault = FAULT_RANGE;
                    n_state = S_TOPRD;
                end else begin
                    s_re = 1'b1;
                    s_raddr = r_fb;
                    n_state = S_WALK2;
                end
            end
            S_WALK2: begin
                if (s_rdata >= t_word'(STACK_DEPTH)) begin
                    n_fault = FAULT_RANGE;
                    n_state = S_TOPRD;
                end else begin
                    n_fb = STACK_AW'(s_rdata);
                    n_cnt = r_cnt - 1'b1;
                    n_state = S_WALK;
                end
            end
            S_EXEC: begin
                n_state = S_RD2;
                unique case (r_ins.fn)
                    F_LIT: begin
                        if (in_stack(tx + 1)) begin
                            s_we = 1'b1;
                            s_waddr = STACK_AW'(tx + 1);
                            s_wdata = t_word'(r_ins.a);
                            n_top = TOP_W'(tx + 1);
                            do_commit = 1'b1;
                            n_state = S_TOPRD;
                        end else begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end
                    end
                    F_OPR: begin
                        if (r_ins.a == OPR_RET) begin
                            if (in_stack(bx + 1) && in_stack(bx + 2)) begin
                                s_re = 1'b1;
                                s_raddr = STACK_AW'(bx + 2);
                                n_addr2 = STACK_AW'(bx + 1);
                            end else begin
                                n_fault = FAULT_RANGE;
                                n_state = S_TOPRD;
                            end
                        end else if (r_ins.a == OPR_NEG || r_ins.a == OPR_ODD) begin
                            if (in_stack(tx)) begin
                                s_re = 1'b1;
                                s_raddr = STACK_AW'(tx);
                                n_addr2 = STACK_AW'(tx);
                            end else begin
                                n_fault = FAULT_RANGE;
                                n_state = S_TOPRD;
                            end
                        end else if (is_binary(r_ins.a)) begin
                            if (in_stack(tx - 1) && in_stack(tx)) begin
                                s_re = 1'b1;
                                s_raddr = STACK_AW'(tx);
                                n_addr2 = STACK_AW'(tx - 1);
                            end else begin
                                n_fault = FAULT_RANGE;
                                n_state = S_TOPRD;
                            end
                        end else begin
                            do_commit = 1'b1;
                            n_state = S_TOPRD;
                        end
                    end
                    F_LOD: begin
                        if (in_stack(fax) && in_stack(tx + 1)) begin
                            s_re = 1'b1;
                            s_raddr = STACK_AW'(fax);
                            n_addr2 = STACK_AW'(fax);
                        end else begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end
                    end
                    F_STO: begin
                        if (in_stack(fax) && in_stack(tx)) begin
                            s_re = 1'b1;
                            s_raddr = STACK_AW'(tx);
                            n_addr2 = STACK_AW'(fax);
                        end else begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end
                    end
                    F_CAL: begin
                        if (in_stack(tx + 1) && in_stack(tx + 3)) begin
                            s_we = 1'b1;
                            s_waddr = STACK_AW'(tx + 1);
                            s_wdata = t_word'(r_fb);
                            n_state = S_CAL2;
                        end else begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end
                    end
                    F_INT: begin
                        if (tx + ax > t_idx'(STACK_DEPTH - 1)) begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end else begin
                            n_top = TOP_W'(tx + ax);
                            do_commit = 1'b1;
                            n_state = S_TOPRD;
                        end
                    end
                    F_JMP: begin
                        np_v = CODE_AW'(r_ins.a);
                        do_commit = 1'b1;
                        n_state = S_TOPRD;
                    end
                    default: begin
                        if (in_stack(tx)) begin
                            s_re = 1'b1;
                            s_raddr = STACK_AW'(tx);
                            n_addr2 = STACK_AW'(tx);
                        end else begin
                            n_fault = FAULT_RANGE;
                            n_state = S_TOPRD;
                        end
                    end
                endcase
            end
            S_RD2: begin
                n_y = s_rdata;
                s_re = 1'b1;
                s_raddr = r_addr2;
                n_state = S_OP;
            end
            S_OP: begin
                n_state = S_TOPRD;
                unique case (r_ins.fn)
                    F_OPR: begin
                        if (r_ins.a == OPR_RET) begin
                            if (s_rdata >= t_word'(STACK_DEPTH)) begin
                                n_fault = FAULT_RANGE;
                            end else begin
                                np_v = r_y[CODE_AW-1:0];
                                n_base = STACK_AW'(s_rdata);
                                n_top = TOP_W'(bx - 1);
                                do_commit = 1'b1;
                            end
                        end else if (r_ins.a == OPR_NEG || r_ins.a == OPR_ODD) begin
                            s_we = 1'b1;
                            s_waddr = STACK_AW'(tx);
                            s_wdata = (r_ins.a == OPR_NEG) ? (t_word'(0) - r_y) :
                                      t_word'(r_y[0]);
                            do_commit = 1'b1;
                        end else if (r_ins.a == OPR_DIV) begin
                            if (r_y == '0) begin
                                n_fault = FAULT_DIV0;
                            end else begin
                                alu_start = 1'b1;
                                n_state = S_DIV;
                            end
                        end else begin
                            s_we = 1'b1;
                            s_waddr = STACK_AW'(tx - 1);
                            s_wdata = alu_res;
                            n_top = TOP_W'(tx - 1);
                            do_commit = 1'b1;
                        end
                    end
                    F_LOD: begin
                        s_we = 1'b1;
                        s_waddr = STACK_AW'(tx + 1);
                        s_wdata = r_y;
                        n_top = TOP_W'(tx + 1);
                        do_commit = 1'b1;
                    end
                    F_STO: begin
                        s_we = 1'b1;
                        s_waddr = r_addr2;
                        s_wdata = r_y;
                        n_top = TOP_W'(tx - 1);
                        do_commit = 1'b1;
                    end
                    default: begin
                        if (r_y != '0) begin
                            np_v = CODE_AW'(r_ins.a);
                        end
                        n_top = TOP_W'(tx - 1);
                        do_commit = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                if (alu_done) begin
                    s_we = 1'b1;
                    s_waddr = STACK_AW'(tx - 1);
                    s_wdata = alu_quo;
                    n_top = TOP_W'(tx - 1);
                    do_commit = 1'b1;
                    n_state = S_TOPRD;
                end
            end
            S_CAL2: begin
                s_we = 1'b1;
                s_waddr = STACK_AW'(tx + 2);
                s_wdata = t_word'(r_base);
                n_state = S_CAL3;
            end
            S_CAL3: begin
                s_we = 1'b1;
                s_waddr = STACK_AW'(tx + 3);
                s_wdata = t_word'(r_np);
                n_base = STACK_AW'(tx + 1);
                np_v = CODE_AW'(r_ins.a);
                do_commit = 1'b1;
                n_state = S_TOPRD;
            end
            S_TOPRD: begin
                n_tv_ok = in_stack(tx);
                s_re = in_stack(tx);
                s_raddr = STACK_AW'(tx);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_o_pc = 11'(r_pc);
                    n_o_base = 12'(r_base);
                    n_o_top = 13'(r_top);
                    n_o_tv = r_tv_ok ? 32'($signed(s_rdata)) : '0;
                    n_o_halt = r_halt;
                    n_o_fault = r_fault;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_commit) begin
            n_pc = np_v;
            n_halt = (np_v == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_base  <= '0;
            r_top   <= '1;
            r_halt  <= 1'b0;
            r_fault <= FAULT_NONE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_base  <= n_base;
            r_top   <= n_top;
            r_halt  <= n_halt;
            r_fault <= n_fault;
            r_ov    <= n_ov;
        end
        r_np <= n_np;   r_fb <= n_fb;     r_addr2 <= n_addr2; r_ins <= n_ins;
        r_cnt <= n_cnt; r_clr <= n_clr;   r_y <= n_y;         r_tv_ok <= n_tv_ok;
        r_o_pc <= n_o_pc;     r_o_base <= n_o_base;   r_o_top <= n_o_top;
        r_o_tv <= n_o_tv;     r_o_halt <= n_o_halt;   r_o_fault <= n_o_fault;
    end

    assign o_valid           = r_ov;
    assign o_prog_counter    = r_o_pc;
    assign o_frame_base      = r_o_base;
    assign o_stack_top_index = r_o_top;
    assign o_stack_top_value = r_o_tv;
    assign o_halted          = r_o_halt;
    assign o_fault_code      = r_o_fault;

`ifndef NO_ASSERTIONS
    a_no_write_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> (r_fault == FAULT_NONE))
        else $error("stack written by a faulted word");
    a_halt_pc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_pc == '0))
        else $error("halted with nonzero pc");
    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ins.fn == F_OPR && r_ins.a == OPR_DIV))
        else $error("divider wait outside a divide");
`endif
endmodule

// ----- verif/tb_pcode_stack_machine_core_unit.sv -----
// Testbench for the p-code stack machine core: directed and random programs, a predictor and a check.
module tb_pcode_stack_machine_core_unit;
    import pcsm_pkg::*;

    typedef struct packed {
        logic [1:0]  opc;
        logic [10:0] caddr;
        logic [2:0]  fn;
        logic [1:0]  lv;
        logic [10:0] a;
    } t_word_in;

    typedef struct packed {
        logic [10:0]        pc;
        logic [11:0]        base;
        logic signed [12:0] top;
        logic signed [31:0] tval;
        logic               halt;
        logic [1:0]         fault;
    } t_word_out;

    localparam int TIMEOUT = 400000;

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    logic [1:0] i_opcode, i_level_diff;
    logic [10:0] i_code_address, i_operand_field;
    logic [2:0] i_func_code;
    logic [10:0] o_prog_counter;
    logic [11:0] o_frame_base;
    logic signed [12:0] o_stack_top_index;
    logic signed [31:0] o_stack_top_value;
    logic o_halted;
    logic [1:0] o_fault_code;

    pcode_stack_machine_core_unit dut (.*);

    // predictor state
    t_instr          m_code [CODE_DEPTH];
    bit              m_code_ok [CODE_DEPTH];
    logic [31:0]     m_stk [STACK_DEPTH];
    bit              m_stk_ok [STACK_DEPTH];
    int              m_pc, m_base, m_top;
    bit              m_halt;

    t_word_in  pending_words [$];
    t_word_out expected_states [$];
    int n_fail, cycles, gap_in, gap_out;

    function automatic bit idx_ok(longint i);
        return i >= 0 && i < STACK_DEPTH;
    endfunction

    function automatic void wr(int i, logic [31:0] v);
        m_stk[i] = v;
        m_stk_ok[i] = 1;
    endfunction

    function automatic bit walk(int lev, output int fb);
        int b1;
        b1 = m_base;
        fb = 0;
        for (int n = 0; n < lev; n++) begin
            if (!idx_ok(b1) || !m_stk_ok[b1]) return 0;
            if (m_stk[b1] >= STACK_DEPTH) return 0;
            b1 = m_stk[b1];
        end
        fb = b1;
        return 1;
    endfunction

    // safe: refuses (returns 1) if an unwritten read would occur; no state change then
    function automatic bit unsafe_exec();
        t_instr ins;
        int t;
        t = m_top;
        if (!m_code_ok[m_pc]) return 1;
        ins = m_code[m_pc];
        case (ins.fn)
            F_OPR: begin
                if (ins.a == OPR_RET) begin
                    if (idx_ok(m_base + 1) && idx_ok(m_base + 2) &&
                        (!m_stk_ok[m_base + 1] || !m_stk_ok[m_base + 2])) return 1;
                end else if (ins.a == OPR_NEG || ins.a == OPR_ODD) begin
                    if (idx_ok(t) && !m_stk_ok[t]) return 1;
                end else if (is_binary(ins.a)) begin
                    if (idx_ok(t - 1) && idx_ok(t) && (!m_stk_ok[t] || !m_stk_ok[t - 1]))
                        return 1;
                end
            end
            F_LOD, F_STO, F_CAL: begin
                int b1;
                b1 = m_base;
                for (int n = 0; n < ins.lv; n++) begin
                    if (!idx_ok(b1)) return 0;
                    if (!m_stk_ok[b1]) return 1;
                    if (m_stk[b1] >= STACK_DEPTH) return 0;
                    b1 = m_stk[b1];
                end
                if (ins.fn == F_LOD && idx_ok(b1 + ins.a) && idx_ok(t + 1) &&
                    !m_stk_ok[b1 + ins.a]) return 1;
                if (ins.fn == F_STO && idx_ok(b1 + ins.a) && idx_ok(t) && !m_stk_ok[t])
                    return 1;
            end
            F_JPC: if (idx_ok(t) && !m_stk_ok[t]) return 1;
            default: ;
        endcase
        return 0;
    endfunction

    function automatic logic [1:0] run_instr();
        t_instr ins;
        int t, np, fb;
        logic signed [31:0] x, y, r;
        ins = m_code[m_pc];
        t = m_top;
        np = (m_pc + 1) % CODE_DEPTH;
        case (ins.fn)
            F_LIT: begin
                if (!idx_ok(t + 1)) return FAULT_RANGE;
                wr(t + 1, 32'(ins.a));
                m_top = t + 1;
            end
            F_OPR: begin
                if (ins.a == OPR_RET) begin
                    if (!idx_ok(m_base + 1) || !idx_ok(m_base + 2)) return FAULT_RANGE;
                    if (m_stk[m_base + 1] >= STACK_DEPTH) return FAULT_RANGE;
                    np = m_stk[m_base + 2] % CODE_DEPTH;
                    m_top = m_base - 1;
                    m_base = m_stk[m_base + 1];
                end else if (ins.a == OPR_NEG || ins.a == OPR_ODD) begin
                    if (!idx_ok(t)) return FAULT_RANGE;
                    m_stk[t] = (ins.a == OPR_NEG) ? -m_stk[t] : {31'd0, m_stk[t][0]};
                end else if (is_binary(ins.a)) begin
                    if (!idx_ok(t - 1) || !idx_ok(t)) return FAULT_RANGE;
                    x = m_stk[t - 1];
                    y = m_stk[t];
                    if (ins.a == OPR_DIV && y == 0) return FAULT_DIV0;
                    case (ins.a)
                        OPR_ADD: r = x + y;
                        OPR_SUB: r = x - y;
                        OPR_MUL: r = x * y;
                        OPR_DIV: r = (x == 32'sh80000000 && y == -1) ? x : x / y;
                        OPR_EQ:  r = 32'(x == y);
                        OPR_NE:  r = 32'(x != y);
                        OPR_LT:  r = 32'(x < y);
                        OPR_GE:  r = 32'(x >= y);
                        OPR_GT:  r = 32'(x > y);
                        default: r = 32'(x <= y);
                    endcase
                    m_stk[t - 1] = r;
                    m_top = t - 1;
                end
            end
            F_LOD: begin
                if (!walk(ins.lv, fb)) return FAULT_RANGE;
                if (!idx_ok(fb + ins.a) || !idx_ok(t + 1)) return FAULT_RANGE;
                wr(t + 1, m_stk[fb + ins.a]);
                m_top = t + 1;
            end
            F_STO: begin
                if (!walk(ins.lv, fb)) return FAULT_RANGE;
                if (!idx_ok(fb + ins.a) || !idx_ok(t)) return FAULT_RANGE;
                wr(fb + ins.a, m_stk[t]);
                m_top = t - 1;
            end
            F_CAL: begin
                if (!walk(ins.lv, fb)) return FAULT_RANGE;
                if (!idx_ok(t + 1) || !idx_ok(t + 3)) return FAULT_RANGE;
                wr(t + 1, fb);
                wr(t + 2, m_base);
                wr(t + 3, np);
                m_base = t + 1;
                np = ins.a;
            end
            F_INT: begin
                if (t + int'(ins.a) > STACK_DEPTH - 1) return FAULT_RANGE;
                m_top = t + int'(ins.a);
            end
            F_JMP: np = ins.a;
            default: begin
                if (!idx_ok(t)) return FAULT_RANGE;
                if (m_stk[t] != 0) np = ins.a;
                m_top = t - 1;
            end
        endcase
        m_pc = np;
        m_halt = (np == 0);
        return FAULT_NONE;
    endfunction

    function automatic t_word_out predict_state(t_word_in w);
        t_word_out o;
        o.fault = FAULT_NONE;
        if (w.opc == OP_LOAD) begin
            m_code[w.caddr] = '{fn: w.fn, lv: w.lv, a: w.a};
            m_code_ok[w.caddr] = 1;
        end else if (w.opc == OP_RESTART) begin
            m_pc = 0; m_base = 0; m_top = -1; m_halt = 0;
            for (int i = 1; i <= 3; i++) wr(i, 0);
        end else if (w.opc == OP_EXEC && !m_halt) begin
            o.fault = run_instr();
        end
        o.pc = m_pc;
        o.base = m_base;
        o.top = m_top;
        o.tval = (idx_ok(m_top) && m_stk_ok[m_top]) ? m_stk[m_top] : 0;
        o.halt = m_halt;
        return o;
    endfunction

    // also guard the top read after an instruction
    function automatic bit top_unknown_after();
        logic [31:0] s_stk [STACK_DEPTH];
        bit          s_ok [STACK_DEPTH];
        int          s_pc, s_base, s_top;
        bit          s_halt;
        bit          bad;
        s_stk = m_stk;
        s_ok = m_stk_ok;
        s_pc = m_pc; s_base = m_base; s_top = m_top; s_halt = m_halt;
        void'(run_instr());
        bad = idx_ok(m_top) && !m_stk_ok[m_top];
        m_stk = s_stk;
        m_stk_ok = s_ok;
        m_pc = s_pc; m_base = s_base; m_top = s_top; m_halt = s_halt;
        return bad;
    endfunction

    function automatic void push_word(logic [1:0] opc, int caddr, int fn, int lv, int a);
        t_word_in w;
        w = '{opc: opc, caddr: 11'(caddr), fn: 3'(fn), lv: 2'(lv), a: 11'(a)};
        pending_words.push_back(w);
    endfunction

    // queue a load word for the program image; exec words are filtered when predictions are rebuilt
    function automatic void load(int addr, int fn, int lv, int a);
        push_word(OP_LOAD, addr, fn, lv, a);
    endfunction

    function automatic int rnd_instr_a(int fn);
        case (fn)
            F_OPR: return $urandom_range(0, 15);
            F_INT: return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 4);
            F_LOD, F_STO: return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                                              : $urandom_range(0, 6);
            F_LIT: return $urandom_range(0, 2047);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // stimulus: words are generated first, then filtered and predicted in order
    t_word_out exp_q [$];
    initial begin
        int n;
        t_word_in w;
        t_word_out o;
        m_pc = 0; m_base = 0; m_top = -1; m_halt = 0;
        // directed
        push_word(OP_RESTART, 0, 0, 0, 0);
        load(0, F_INT, 0, 3);
        load(1, F_LIT, 0, 2047);
        load(2, F_OPR, 0, OPR_NEG);
        load(3, F_LIT, 0, 0);
        load(4, F_OPR, 0, OPR_DIV);
        load(5, F_OPR, 0, OPR_ODD);
        load(6, F_STO, 3, 2047);
        load(7, F_CAL, 3, 9);
        load(8, F_JMP, 0, 0);
        load(9, F_LOD, 1, 3);
        load(10, F_JPC, 0, 12);
        load(2047, F_OPR, 0, 7);
        load(12, F_OPR, 0, OPR_RET);
        for (int i = 0; i < 10; i++) push_word(OP_EXEC, 2047, 7, 3, 2047);
        push_word(OP_NONE, 2047, 7, 3, 2047);
        push_word(OP_RESTART, 0, 0, 0, 0);
        // random: programs of small slots, run with mostly exec words
        n = 0;
        while (n < 1650) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 20) push_word(OP_LOAD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                  : $urandom_range(0, 31), $urandom_range(0, 7),
                                  $urandom_range(0, 3), 0);
            else if (k < 24) push_word(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
            else if (k < 26) push_word(OP_NONE, $urandom, $urandom, $urandom, $urandom);
            else push_word(OP_EXEC, $urandom, $urandom, $urandom, $urandom);
            w = pending_words.pop_back();
            if (w.opc == OP_LOAD) w.a = 11'(rnd_instr_a(w.fn));
            if (w.opc == OP_LOAD && w.fn == F_JMP && $urandom_range(0, 3) == 0) w.a = 0;
            pending_words.push_back(w);
            n++;
        end
        // the directed words also need filtering: rebuild predictions in order
        begin
            t_word_in all_words [$];
            all_words = pending_words;
            pending_words.delete();
            m_pc = 0; m_base = 0; m_top = -1; m_halt = 0;
            foreach (m_code_ok[i]) m_code_ok[i] = 0;
            foreach (m_stk_ok[i]) m_stk_ok[i] = 0;
            foreach (all_words[i]) begin
                w = all_words[i];
                if (w.opc == OP_EXEC && !m_halt && (unsafe_exec() || top_unknown_after()))
                    w.opc = OP_RESTART;
                o = predict_state(w);
                pending_words.push_back(w);
                exp_q.push_back(o);
            end
        end
    end

    // drive words with random gaps; each accepted word moves its prediction from the rebuilt queue to the check queue
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 0;
            gap_in <= $urandom_range(0, 8);
        end else if (i_valid && o_ready) begin
            expected_states.push_back(exp_q.pop_front());
            if (gap_in == 0 && pending_words.size() > 0 && $urandom_range(0, 3) != 0) begin
                t_word_in w;
                w = pending_words.pop_front();
                {i_opcode, i_code_address, i_func_code, i_level_diff, i_operand_field} <= w;
                i_valid <= 1;
            end else begin
                i_valid <= 0;
            end
            gap_in <= $urandom_range(0, 8) * $urandom_range(0, 1);
        end else if (!i_valid && pending_words.size() > 0 && exp_q.size() > 0) begin
            if (gap_in == 0) begin
                t_word_in w;
                w = pending_words.pop_front();
                {i_opcode, i_code_address, i_func_code, i_level_diff, i_operand_field} <= w;
                i_valid <= 1;
            end else begin
                gap_in <= gap_in - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            gap_out <= 0;
        end else begin
            if (o_valid && i_ready) begin
                t_word_out e, g;
                g = '{pc: o_prog_counter, base: o_frame_base, top: o_stack_top_index,
                      tval: o_stack_top_value, halt: o_halted, fault: o_fault_code};
                if (expected_states.size() == 0) begin
                    $error("unexpected word pc=%0d", g.pc);
                    n_fail++;
                end else begin
                    e = expected_states.pop_front();
                    if (g.pc !== e.pc) begin
                        $error("prog_counter exp %0d got %0d", e.pc, g.pc); n_fail++;
                    end
                    if (g.base !== e.base) begin
                        $error("frame_base exp %0d got %0d", e.base, g.base); n_fail++;
                    end
                    if (g.top !== e.top) begin
                        $error("stack_top_index exp %0d got %0d", e.top, g.top); n_fail++;
                    end
                    if (g.tval !== e.tval) begin
                        $error("stack_top_value exp %0d got %0d", e.tval, g.tval); n_fail++;
                    end
                    if (g.halt !== e.halt) begin
                        $error("halted exp %0d got %0d", e.halt, g.halt); n_fail++;
                    end
                    if (g.fault !== e.fault) begin
                        $error("fault_code exp %0d got %0d", e.fault, g.fault); n_fail++;
                    end
                end
                gap_out <= $urandom_range(0, 8) * $urandom_range(0, 1);
                i_ready <= 0;
            end else if (gap_out == 0) begin
                i_ready <= 1;
            end else begin
                gap_out <= gap_out - 1;
            end
        end
    end

    initial begin
        cycles = 0;
        n_fail = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        {i_opcode, i_code_address, i_func_code, i_level_diff, i_operand_field} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        wait (exp_q.size() == 0 && !i_valid && expected_states.size() == 0 || cycles > TIMEOUT);
        if (cycles > TIMEOUT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        repeat (100) @(posedge i_clk);
        if (n_fail == 0 && expected_states.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/pcsm_pkg.sv
rtl/pcsm_ram.sv
rtl/pcsm_alu.sv
rtl/pcode_stack_machine_core_unit.sv
verif/tb_pcode_stack_machine_core_unit.sv
